/* src/aspc_pkg.sv */
// Package for the activity selection block: the field widths and the entry types
// that the cells and the top level share. It depends on nothing else.
`default_nettype none

package aspc_pkg;

    // Widths of the item fields.
    localparam int TIME_W = 16;
    localparam int POS_W  = 7;

    // One interval as it is held in the sorting chain.
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [POS_W-1:0]  number;
    } aspc_entry_t;

    // An interval with its valid flag.
    typedef struct packed {
        logic        valid;
        aspc_entry_t entry;
    } aspc_slot_t;

    // Mode of the chain for the current cycle.
    typedef struct packed {
        logic insert;
        logic shift;
    } aspc_ctrl_t;

endpackage

`default_nettype wire

/* src/aspc_cell.sv */
// One cell of the sorting chain: it holds one interval and passes the later of
// the held and the arriving interval to its right neighbor. Uses aspc_pkg.
`default_nettype none

module aspc_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  aspc_pkg::aspc_ctrl_t ctrl,
    input  aspc_pkg::aspc_slot_t carry_in,
    input  aspc_pkg::aspc_slot_t right_held,
    output aspc_pkg::aspc_slot_t held,
    output aspc_pkg::aspc_slot_t carry_out
);
    import aspc_pkg::*;

    logic       held_valid_reg, held_valid_next;
    aspc_entry_t held_entry_reg, held_entry_next;
    logic       carry_valid_reg, carry_valid_next;
    aspc_entry_t carry_entry_reg, carry_entry_next;

    // Insert keeps the earlier end time; on equal end times the lower arrival
    // number stays, since a displaced older entry can meet a newer one here.
    // Shift moves the whole row one cell left.
    always_comb begin
        held_valid_next  = held_valid_reg;
        held_entry_next  = held_entry_reg;
        carry_valid_next = 1'b0;
        carry_entry_next = carry_in.entry;
        if (ctrl.shift) begin
            held_valid_next = right_held.valid;
            held_entry_next = right_held.entry;
        end else if (ctrl.insert && carry_in.valid) begin
            if (!held_valid_reg) begin
                held_valid_next = 1'b1;
                held_entry_next = carry_in.entry;
            end else if ((carry_in.entry.end_time < held_entry_reg.end_time) ||
                         ((carry_in.entry.end_time == held_entry_reg.end_time) &&
                          (carry_in.entry.number < held_entry_reg.number))) begin
                held_entry_next  = carry_in.entry;
                carry_valid_next = 1'b1;
                carry_entry_next = held_entry_reg;
            end else begin
                carry_valid_next = 1'b1;
            end
        end
    end

    // Valid flags are cleared by reset; the entries need none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            carry_valid_reg <= 1'b0;
        end else begin
            held_valid_reg  <= held_valid_next;
            carry_valid_reg <= carry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_entry_reg  <= held_entry_next;
        carry_entry_reg <= carry_entry_next;
    end

    assign held.valid      = held_valid_reg;
    assign held.entry      = held_entry_reg;
    assign carry_out.valid = carry_valid_reg;
    assign carry_out.entry = carry_entry_reg;

endmodule

`default_nettype wire

/* src/activity_selection_positions_core.sv */
// Greedy activity selection by earliest finish. Intervals load at one item per
// cycle into a chain of MAX_INTERVALS cells that keeps them sorted by end time
// (ties to the earlier arrival) as they ripple one cell per cycle. After the item
// marked last, the block stops taking items while the chain settles, then shifts
// the chain out one cell per cycle while the result side is not stalled, emitting
// the arrival number of each selected interval. Items beyond MAX_INTERVALS are
// dropped and flagged on every result of the set.
// Depends on aspc_pkg and aspc_cell.
`default_nettype none

module activity_selection_positions_core #(
    parameter int MAX_INTERVALS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // start_time [15:0], end_time [31:16]
    input  wire         s_tlast,   // last_interval
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // position [6:0], zero fill [7]
    output logic        m_tlast,   // final_result
    output logic [0:0]  m_tuser    // overflow [0]
);
    import aspc_pkg::*;

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_INTERVALS);
    localparam logic [CNT_W-1:0] DRAIN_END = CNT_W'(MAX_INTERVALS - 1);

    // Controller states.
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  drain_reg, drain_next;
    logic              drop_reg, drop_next;
    logic [TIME_W-1:0] last_end_reg, last_end_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [POS_W-1:0]  pend_pos_reg, pend_pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_final_reg, out_final_next;
    logic              out_ovf_reg, out_ovf_next;

    aspc_ctrl_t ctrl;
    aspc_slot_t held  [MAX_INTERVALS];
    aspc_slot_t carry [MAX_INTERVALS+1];
    aspc_slot_t head;
    logic       in_accept;
    logic       slot_free;
    logic       take;

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign head      = held[0];
    assign take      = !pend_valid_reg || (head.entry.start_time > last_end_reg);

    // New interval enters the chain at the left end unless the store is full.
    assign carry[0].valid            = in_accept && (count_reg < MAX_CNT);
    assign carry[0].entry.start_time = s_tdata[15:0];
    assign carry[0].entry.end_time   = s_tdata[31:16];
    assign carry[0].entry.number     = POS_W'(count_reg) + POS_W'(1);

    assign ctrl.insert = (state_reg != ST_SCAN);
    assign ctrl.shift  = (state_reg == ST_SCAN) && slot_free && head.valid;

    // Chain of sorting cells.
    for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
        aspc_slot_t right;
        if (k == MAX_INTERVALS - 1) begin : g_end
            assign right = '0;
        end else begin : g_mid
            assign right = held[k+1];
        end
        aspc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .carry_in   (carry[k]),
            .right_held (right),
            .held       (held[k]),
            .carry_out  (carry[k+1])
        );
    end

    // Controller: load, let the chain settle, then scan and select.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        drain_next      = drain_reg;
        drop_next       = drop_reg;
        last_end_next   = last_end_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pos_next    = out_pos_reg;
        out_final_next  = out_final_reg;
        out_ovf_next    = out_ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_accept) begin
                    if (count_reg < MAX_CNT) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast) begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + CNT_W'(1);
                if (drain_reg == DRAIN_END) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (slot_free) begin
                    if (head.valid) begin
                        // A newly taken interval releases the one held back.
                        if (take) begin
                            if (pend_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_pos_next   = pend_pos_reg;
                                out_final_next = 1'b0;
                                out_ovf_next   = drop_reg;
                            end
                            pend_valid_next = 1'b1;
                            pend_pos_next   = head.entry.number;
                            last_end_next   = head.entry.end_time;
                        end
                    end else begin
                        // Chain empty: the held-back interval is the final one.
                        out_valid_next  = 1'b1;
                        out_pos_next    = pend_pos_reg;
                        out_final_next  = 1'b1;
                        out_ovf_next    = drop_reg;
                        pend_valid_next = 1'b0;
                        count_next      = '0;
                        drop_next       = 1'b0;
                        state_next      = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            drain_reg      <= '0;
            drop_reg       <= 1'b0;
            last_end_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            drain_reg      <= drain_next;
            drop_reg       <= drop_next;
            last_end_reg   <= last_end_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_pos_reg  <= pend_pos_next;
        out_pos_reg   <= out_pos_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pos_reg};
    assign m_tlast  = out_final_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

/* src/aspc_checker.sv */
// Port-level checks for activity_selection_positions_core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module aspc_checker #(
    parameter int MAX_INTERVALS = 32
) (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tready,
    input wire [7:0] m_tdata,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire       m_tlast,
    input wire [0:0] m_tuser
);

    // A stalled result item holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Positions are one-based and within the store.
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] != 7'd0) && (m_tdata[6:0] <= 7'(MAX_INTERVALS)))
        else $error("position out of range");

    // After the final item of a set, the next set must still be loaded first.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result item right after the final one");

    // No input is taken while a selection is being emitted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during selection");

endmodule

bind activity_selection_positions_core aspc_checker #(
    .MAX_INTERVALS(MAX_INTERVALS)
) u_aspc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
